[rtl/replay_window_duplicate_check_macros.svh]
// Assertion macros shared by the checking code of the replay window block.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef REPLAY_WINDOW_DUPLICATE_CHECK_MACROS_SVH
`define REPLAY_WINDOW_DUPLICATE_CHECK_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RWDC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RWDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/rwdc_pkg.sv]
package rwdc_pkg;

	localparam int unsigned ID_W = 64;

	typedef logic [ID_W-1:0] id_t;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT    = 2'd0,
		VERDICT_DUPLICATE = 2'd1,
		VERDICT_TOO_OLD   = 2'd2
	} verdict_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CMP  = 3'b010,
		S_INS  = 3'b100
	} state_t;

	// Control broadcast from the sequencer to every cell of the row.
	typedef struct packed {
		logic capture;
		logic halve;
		logic insert;
	} cell_ctrl_t;

	// Registered compare result of one cell.
	typedef struct packed {
		logic lt;
		logic eq;
	} cell_flags_t;

endpackage

[rtl/rwdc_cell.sv]
module rwdc_cell (
	input  logic                 clk,
	input  rwdc_pkg::cell_ctrl_t ctrl,
	input  rwdc_pkg::id_t        key,
	input  logic                 valid,
	input  rwdc_pkg::id_t        upper,
	input  rwdc_pkg::id_t        left_value,
	input  logic                 left_lt,
	output rwdc_pkg::id_t        value,
	output rwdc_pkg::cell_flags_t flags
);

	rwdc_pkg::id_t        value_q;
	rwdc_pkg::id_t        view;
	rwdc_pkg::cell_flags_t flags_s1;

	// The compare sees the entry as it stands after a possible half drop.
	assign view = ctrl.halve ? upper : value_q;

	always_ff @(posedge clk) begin
		if (ctrl.halve) begin
			value_q <= upper;
		end else if (ctrl.insert && !flags_s1.lt) begin
			value_q <= left_lt ? key : left_value;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			flags_s1.lt <= valid && (view < key);
			flags_s1.eq <= valid && (view == key);
		end
	end

	assign value = value_q;
	assign flags = flags_s1;

endmodule

[rtl/replay_window_duplicate_check.sv]
// An accepted transfer passes through the compare state and then the insert state;
// done and the verdict are registered as the insert state ends. A new identifier can
// be taken during that insert state; busy is high for the compare cycle only,
// which every cell of the sorted row spends comparing its entry against the identifier.
// Reset: arst_n clears the sequencer, the fill count and done at once; the stored
// identifiers are left as they are and count as empty. Results cannot be stalled.
module replay_window_duplicate_check #(
	parameter int unsigned WINDOW = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] packet_id,
	output logic        done,
	output logic [1:0]  verdict
);

	// The row holds twice the window; the count must reach that figure itself.
	localparam int unsigned DEPTH = 2 * WINDOW;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	rwdc_pkg::state_t      state_q;
	rwdc_pkg::state_t      state_d;
	rwdc_pkg::id_t         key_q;
	logic [CNT_W-1:0]      fill_q;
	logic [CNT_W-1:0]      view_fill;
	logic                  full;
	logic                  accept;
	rwdc_pkg::cell_ctrl_t  ctrl;
	rwdc_pkg::verdict_t    verdict_d;
	rwdc_pkg::verdict_t    verdict_q;
	logic                  done_q;
	logic                  dup_any;
	logic                  too_old;

	rwdc_pkg::id_t         cell_value [DEPTH];
	rwdc_pkg::cell_flags_t cell_flags [DEPTH];
	logic [DEPTH-1:0]      eq_vec;

	// A transfer is taken whenever the compare cycle is not running, including the
	// insert cycle of the previous identifier: the insert only reads key_q before the
	// edge, so the new identifier may overwrite it at that same edge.
	assign busy   = (state_q == rwdc_pkg::S_CMP);
	assign accept = start && !busy;

	// When the row is full, the oldest half is dropped in the compare cycle, whatever
	// the verdict turns out to be. The compare already looks at the shifted contents.
	assign full      = (fill_q == CNT_W'(DEPTH));
	assign view_fill = full ? CNT_W'(WINDOW) : fill_q;

	always_comb begin
		ctrl.capture = (state_q == rwdc_pkg::S_CMP);
		ctrl.halve   = (state_q == rwdc_pkg::S_CMP) && full;
		ctrl.insert  = (state_q == rwdc_pkg::S_INS) && (verdict_d == rwdc_pkg::VERDICT_ACCEPT);
	end

	// The row of cells. Each cell keeps one identifier in ascending order and, on an
	// insert, either keeps its entry (when it is below the key), takes the key (when
	// its left neighbour is below the key or it is the first cell) or takes its left
	// neighbour's entry, so the row opens a gap at the sorted position for the key.
	// Appending is the same move with the gap just past the last valid entry.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		rwdc_pkg::id_t upper;
		rwdc_pkg::id_t left_value;
		logic          left_lt;
		logic          valid;

		if (i < WINDOW) begin : g_low
			assign upper = cell_value[i + WINDOW];
		end else begin : g_high
			assign upper = cell_value[i];
		end

		if (i == 0) begin : g_first
			assign left_value = key_q;
			assign left_lt    = 1'b1;
		end else begin : g_rest
			assign left_value = cell_value[i - 1];
			assign left_lt    = cell_flags[i - 1].lt;
		end

		assign valid = (CNT_W'(i) < view_fill);

		rwdc_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.key        (key_q),
			.valid      (valid),
			.upper      (upper),
			.left_value (left_value),
			.left_lt    (left_lt),
			.value      (cell_value[i]),
			.flags      (cell_flags[i])
		);

		assign eq_vec[i] = cell_flags[i].eq;
	end

	// Verdict in the insert cycle. An exact match anywhere is a duplicate. With at
	// least a window's worth kept, a key that is not above the first entry (and not
	// equal to it) is too old. An identifier above the newest entry always has the
	// first flag set, so it can never be taken for a too-old one.
	assign dup_any = |eq_vec;
	assign too_old = (fill_q >= CNT_W'(WINDOW)) && !cell_flags[0].lt;

	always_comb begin
		if (dup_any) begin
			verdict_d = rwdc_pkg::VERDICT_DUPLICATE;
		end else if (too_old) begin
			verdict_d = rwdc_pkg::VERDICT_TOO_OLD;
		end else begin
			verdict_d = rwdc_pkg::VERDICT_ACCEPT;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rwdc_pkg::S_IDLE: begin
				if (start) begin
					state_d = rwdc_pkg::S_CMP;
				end
			end
			rwdc_pkg::S_CMP: begin
				state_d = rwdc_pkg::S_INS;
			end
			rwdc_pkg::S_INS: begin
				state_d = start ? rwdc_pkg::S_CMP : rwdc_pkg::S_IDLE;
			end
			default: begin
				state_d = rwdc_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rwdc_pkg::S_IDLE;
			fill_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == rwdc_pkg::S_INS);
			if (ctrl.halve) begin
				fill_q <= CNT_W'(WINDOW);
			end else if (ctrl.insert) begin
				fill_q <= fill_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= packet_id;
		end
		if (state_q == rwdc_pkg::S_INS) begin
			verdict_q <= verdict_d;
		end
	end

	assign done    = done_q;
	assign verdict = verdict_q;

endmodule

[rtl/rwdc_checker.sv]
`include "replay_window_duplicate_check_macros.svh"

module rwdc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  verdict
);

	logic accepted;

	assign accepted = start && !busy;

	`RWDC_ASSERT_NEXT(a_busy_after_accept, accepted, busy, "no compare cycle after a transfer")
	`RWDC_ASSERT_NEXT(a_result_follows, accepted, ##2 done, "verdict missing three cycles on")
	`RWDC_ASSERT_NOW(a_no_invented_result, done, $past(accepted, 3), "verdict without a transfer")
	`RWDC_ASSERT_NEXT(a_busy_single, busy, !busy, "busy held beyond the compare cycle")
	`RWDC_ASSERT_NOW(a_verdict_legal, done, verdict <= rwdc_pkg::VERDICT_TOO_OLD, "verdict code out of range")

endmodule

bind replay_window_duplicate_check rwdc_checker u_rwdc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.verdict    (verdict)
);

[tb/replay_verdict_checker.sv]
`default_nettype none

module replay_verdict_checker #(
	parameter int unsigned WINDOW = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic [63:0] packet_id,
	input  wire logic        done,
	input  wire logic [1:0]  verdict,
	output int               fail_count,
	output int               pending
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = 2 * WINDOW;

	typedef struct {
		rwdc_pkg::id_t      id;
		rwdc_pkg::verdict_t verdict;
	} due_t;

	// Sorted copy of the identifiers the block should be holding.
	rwdc_pkg::id_t kept_ids [DEPTH];
	int unsigned   kept_count = 0;
	due_t          verdicts_due [$];
	due_t          head;
	due_t          fresh;

	function automatic rwdc_pkg::verdict_t judge_arrival(input rwdc_pkg::id_t id);
		int unsigned slot;
		int unsigned k;
		if (kept_count == DEPTH) begin
			for (k = 0; k < WINDOW; k++)
				kept_ids[k] = kept_ids[k + WINDOW];
			kept_count = WINDOW;
		end
		if (kept_count == 0 || id > kept_ids[kept_count - 1]) begin
			kept_ids[kept_count] = id;
			kept_count++;
			return rwdc_pkg::VERDICT_ACCEPT;
		end
		if (kept_count >= WINDOW && id < kept_ids[0])
			return rwdc_pkg::VERDICT_TOO_OLD;
		slot = 0;
		while (slot < kept_count && kept_ids[slot] < id)
			slot++;
		if (kept_ids[slot] == id)
			return rwdc_pkg::VERDICT_DUPLICATE;
		for (k = kept_count; k > slot; k--)
			kept_ids[k] = kept_ids[k - 1];
		kept_ids[slot] = id;
		kept_count++;
		return rwdc_pkg::VERDICT_ACCEPT;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (done !== 1'b0) begin
				if (verdicts_due.size() == 0) begin
					$error("verdict: expected nothing, actual %0d", verdict);
					fail_count++;
				end else begin
					head = verdicts_due.pop_front();
					if (verdict !== head.verdict) begin
						$error("verdict for id %h: expected %0d, actual %0d",
							head.id, head.verdict, verdict);
						fail_count++;
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0) begin
				fresh.id = packet_id;
				fresh.verdict = judge_arrival(packet_id);
				verdicts_due = {verdicts_due, fresh};
			end
			pending = verdicts_due.size();
		end
	end

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned   WINDOW     = 64;
	localparam int            RANDOM_IDS = 1840;
	// The slowest honest run stays far below this limit, which leaves a wide margin.
	localparam int            CYCLE_LIMIT = 500000;
	localparam rwdc_pkg::id_t ALL_ONES   = {64{1'b1}};

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	rwdc_pkg::id_t packet_id;
	logic          done;
	logic [1:0]    verdict;
	int            fail_count;
	int            pending;

	// Largest identifier offered so far. Anything above the newest stored entry is
	// always appended, so this is also the newest identifier held by the block.
	rwdc_pkg::id_t newest;
	bit            have_newest = 1'b0;
	// Recently offered identifiers, replayed to provoke duplicates and stale hits.
	rwdc_pkg::id_t sent_log [$];

	replay_window_duplicate_check #(
		.WINDOW(WINDOW)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.packet_id (packet_id),
		.done      (done),
		.verdict   (verdict)
	);

	replay_verdict_checker #(
		.WINDOW(WINDOW)
	) verdict_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.packet_id (packet_id),
		.done      (done),
		.verdict   (verdict),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake or a missing verdict ends the run here.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic rwdc_pkg::id_t rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Gap after a transfer: mostly none or a short one, now and then a long one.
	// Within burst stretches the sender never idles, so back-to-back transfers
	// are taken in the insert state of the identifier before them.
	function automatic int gap_after(input int n);
		int roll;
		roll = $urandom_range(0, 99);
		if ((n % 300) < 60)
			return 0;
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Offers one identifier and holds it until the block takes it, that is until a
	// rising edge at which busy is low. Start is only lowered when a gap follows,
	// so a back-to-back transfer never sees start dropped and raised in one step.
	task automatic offer_id(input rwdc_pkg::id_t id, input int gap);
		start <= 1'b1;
		packet_id <= id;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		if (!have_newest || id > newest) begin
			newest = id;
			have_newest = 1'b1;
		end
		sent_log = {sent_log, id};
		if (sent_log.size() > 256)
			void'(sent_log.pop_front());
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Holds the sender back until every verdict owed has come out, after first
	// letting the checker log the last transfer.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	// Chooses the next random identifier. The bulk of the traffic is a rising
	// sequence with small steps, which keeps the store filling and halving; the
	// rest lands in the gaps just below the newest entry, replays earlier
	// identifiers, reaches far below the kept range, or jumps well ahead so
	// that the upper bits get exercised too. The all-ones value is held back
	// for the very end, as once stored it would remain the newest for good.
	function automatic rwdc_pkg::id_t next_id();
		int            roll;
		rwdc_pkg::id_t step;
		rwdc_pkg::id_t room;
		roll = $urandom_range(0, 99);
		if (!have_newest)
			return rwdc_pkg::id_t'($urandom_range(0, 1000));
		if (roll < 50) begin
			step = rwdc_pkg::id_t'($urandom_range(1, 8));
			if (ALL_ONES - 1 - newest >= step)
				return newest + step;
			return rand64() % newest;
		end
		if (roll < 65) begin
			step = rwdc_pkg::id_t'($urandom_range(0, 24));
			return (newest >= step) ? newest - step : '0;
		end
		if (roll < 80)
			return sent_log[$urandom_range(0, sent_log.size() - 1)];
		if (roll < 90)
			return rand64() % (newest / 2 + 1);
		if (roll < 98)
			return (newest != '0) ? rand64() % newest : rand64() % 64'd4096;
		room = ALL_ONES - 1 - newest;
		if (room == '0)
			return rand64() % newest;
		return newest + 1 + rand64() % (room / 4 + 1);
	endfunction

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		packet_id = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening on an almost empty store: the first identifier goes
		// into an empty store, lower ones are slotted in at the front and in the
		// middle without any age check, and exact repeats of the oldest, the
		// newest and of zero come back as duplicates.
		offer_id(64'd100, 0);
		offer_id(64'd50, 1);
		offer_id(64'd75, 0);
		offer_id(64'd50, 2);
		offer_id(64'd100, 0);
		offer_id(64'd200, 3);
		offer_id(64'd0, 0);
		offer_id(64'd0, 0);
		offer_id(64'd199, 1);
		offer_id(64'd201, 0);
		offer_id(64'd75, 0);
		drain();

		// Random part. Every few hundred transfers the sender stops and waits for
		// the block to catch up completely before carrying on.
		for (int n = 0; n < RANDOM_IDS; n++) begin
			offer_id(next_id(), gap_after(n));
			if (n % 400 == 399)
				drain();
		end

		// Closing directed transfers: the all-ones identifier is appended, then
		// repeated as a duplicate, and zero, long since dropped from a well-filled
		// store, should be turned away as too old.
		offer_id(ALL_ONES, 0);
		offer_id(ALL_ONES, 0);
		offer_id(64'd0, 0);
		drain();

		// A short spell after the last verdict catches any stray strobe.
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

[files.f]
+incdir+rtl
rtl/rwdc_pkg.sv
rtl/rwdc_cell.sv
rtl/replay_window_duplicate_check.sv
rtl/rwdc_checker.sv
tb/replay_verdict_checker.sv
tb/testbench.sv
